// ===== rtl/selective_repeat_receiver_core_macros.svh =====
// Assertion macros shared by the selective-repeat receiver modules.
`ifndef SELECTIVE_REPEAT_RECEIVER_CORE_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SRR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srr_pkg.sv =====
// Shared constants, codes and types of the selective-repeat receiver.
package srr_pkg;

    localparam int WINDOW            = 8;
    localparam int MAX_PAYLOAD_BYTES = 1024;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WINC_W = SLOT_W + 1;
    localparam int WIN_W  = 4;
    localparam int SEQ_W  = 32;
    localparam int TAG_W  = 16;
    localparam int LEN_W  = 11;
    localparam int KIND_W = 2;
    localparam int SLOT_DATA_W = TAG_W + LEN_W;

    localparam logic [WIN_W-1:0] WIN_RESET = 4'd8;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_FIN  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_FINACK  = 2'd1,
        KIND_DELIVER = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_READ
    } state_t;

    typedef struct packed {
        logic              set_en;
        logic [SLOT_W-1:0] set_idx;
        logic [SEQ_W-1:0]  set_seq;
        logic              clr_en;
        logic [SLOT_W-1:0] clr_idx;
    } cam_cmd_t;

    typedef struct packed {
        logic              seq_hit;
        logic              exp_hit;
        logic [SLOT_W-1:0] exp_idx;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
    } cam_stat_t;

endpackage

// ===== rtl/srr_ram.sv =====
// Generic single-port-write, registered-read RAM.
module srr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [DATA_W-1:0]        rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/srr_cam.sv =====
// Slot sequence numbers and occupancy, matched against two keys in parallel.
`include "selective_repeat_receiver_core_macros.svh"
module srr_cam
    import srr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cam_cmd_t           cmd,
    input  logic [SEQ_W-1:0]   seq_key,
    input  logic [SEQ_W-1:0]   exp_key,
    input  logic [WINC_W-1:0]  win,
    output cam_stat_t          stat
);
    logic [WINDOW-1:0] valid_reg;
    logic [SEQ_W-1:0]  seq_reg [WINDOW];

    logic [WINDOW-1:0] seq_match;
    logic [WINDOW-1:0] exp_match;
    logic [WINDOW-1:0] free_ok;

    always_comb
    begin
        stat = '0;
        for (int i = 0; i < WINDOW; i++)
        begin
            seq_match[i] = valid_reg[i] && (seq_reg[i] == seq_key);
            exp_match[i] = valid_reg[i] && (seq_reg[i] == exp_key);
            free_ok[i]   = !valid_reg[i] && (WINC_W'(i) < win);
        end
        stat.seq_hit    = |seq_match;
        stat.exp_hit    = |exp_match;
        stat.free_found = |free_ok;
        // lowest index wins
        for (int i = WINDOW - 1; i >= 0; i--)
        begin
            if (exp_match[i])
            begin
                stat.exp_idx = SLOT_W'(i);
            end
            if (free_ok[i])
            begin
                stat.free_idx = SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.set_en)
            begin
                valid_reg[cmd.set_idx] <= 1'b1;
            end
            if (cmd.clr_en)
            begin
                valid_reg[cmd.clr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.set_en)
        begin
            seq_reg[cmd.set_idx] <= cmd.set_seq;
        end
    end

    `SRR_ASSERT_IMPL(a_set_free_slot, cmd.set_en, !valid_reg[cmd.set_idx], "store into occupied slot")
    `SRR_ASSERT_IMPL(a_no_dup_exp, 1'b1, $countones(exp_match) <= 1, "expected number held twice")
endmodule

// ===== rtl/srr_ctrl.sv =====
// Receiver sequencer: classify items, update slots, emit acks and deliveries.
`include "selective_repeat_receiver_core_macros.svh"
module srr_ctrl
    import srr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [63:0]              s_tdata,
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [63:0]              m_tdata,
    output logic [KIND_W-1:0]        m_tuser,
    output logic                     m_tlast,
    input  logic                     cfg_wr_en,
    input  logic [WIN_W-1:0]         cfg_wr_data,
    output cam_cmd_t                 cam_cmd,
    output logic [SEQ_W-1:0]         seq_key,
    output logic [SEQ_W-1:0]         exp_key,
    output logic [WINC_W-1:0]        win,
    input  cam_stat_t                cam_stat,
    output logic                     ram_we,
    output logic [SLOT_W-1:0]        ram_waddr,
    output logic [SLOT_DATA_W-1:0]   ram_wdata,
    output logic                     ram_re,
    output logic [SLOT_W-1:0]        ram_raddr,
    input  logic [SLOT_DATA_W-1:0]   ram_rdata
);
    state_t            state_reg, state_next;
    logic [WIN_W-1:0]  win_cfg_reg;
    logic [SEQ_W-1:0]  exp_reg, exp_next;
    logic              ack_pend_reg, ack_pend_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic              act_reg, act_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [SEQ_W-1:0]  deliv_num_reg, deliv_num_next;

    kind_t             out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]  out_num_reg, out_num_next;
    logic [TAG_W-1:0]  out_tag_reg, out_tag_next;
    logic [LEN_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;

    logic              load;
    logic              out_free;
    logic [SEQ_W-1:0]  seq_off;

    always_comb
    begin
        if (win_cfg_reg == '0)
        begin
            win = WINC_W'(1);
        end
        else if (32'(win_cfg_reg) > WINDOW)
        begin
            win = WINC_W'(WINDOW);
        end
        else
        begin
            win = WINC_W'(win_cfg_reg);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign seq_off  = seq_reg - exp_reg;
    assign seq_key  = seq_reg;
    assign exp_key  = exp_reg;

    assign ram_waddr = cam_stat.free_idx;
    assign ram_wdata = {tag_reg, len_reg};
    assign ram_raddr = cam_stat.exp_idx;

    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        ack_pend_next  = ack_pend_reg;
        act_next       = act_reg;
        seq_next       = seq_reg;
        tag_next       = tag_reg;
        len_next       = len_reg;
        deliv_num_next = deliv_num_reg;
        out_kind_next  = out_kind_reg;
        out_num_next   = out_num_reg;
        out_tag_next   = out_tag_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;
        load           = 1'b0;
        s_tready       = 1'b0;
        cam_cmd        = '0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    act_next   = s_tuser;
                    seq_next   = s_tdata[SEQ_W-1:0];
                    tag_next   = s_tdata[SEQ_W+TAG_W-1:SEQ_W];
                    len_next   = s_tdata[SEQ_W+TAG_W+LEN_W-1:SEQ_W+TAG_W];
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                priority if (act_reg == ACT_FIN)
                begin
                    if (out_free)
                    begin
                        load          = 1'b1;
                        out_kind_next = KIND_FINACK;
                        out_num_next  = exp_reg;
                        out_tag_next  = '0;
                        out_len_next  = '0;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if ((len_reg == '0) || (len_reg > LEN_W'(MAX_PAYLOAD_BYTES)))
                begin
                    // drop malformed or empty item
                    state_next = S_IDLE;
                end
                else if (seq_reg < exp_reg)
                begin
                    if (out_free)
                    begin
                        load          = 1'b1;
                        out_kind_next = KIND_ACK;
                        out_num_next  = seq_reg;
                        out_tag_next  = '0;
                        out_len_next  = '0;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else if (cam_stat.seq_hit)
                begin
                    ack_pend_next = 1'b1;
                    state_next    = S_SCAN;
                end
                else if ((seq_off < SEQ_W'(win)) && cam_stat.free_found)
                begin
                    cam_cmd.set_en  = 1'b1;
                    cam_cmd.set_idx = cam_stat.free_idx;
                    cam_cmd.set_seq = seq_reg;
                    ram_we          = 1'b1;
                    ack_pend_next   = 1'b1;
                    state_next      = S_SCAN;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                priority if (ack_pend_reg)
                begin
                    if (out_free)
                    begin
                        load          = 1'b1;
                        out_kind_next = KIND_ACK;
                        out_num_next  = seq_reg;
                        out_tag_next  = '0;
                        out_len_next  = '0;
                        out_last_next = !cam_stat.exp_hit;
                        ack_pend_next = 1'b0;
                    end
                end
                else if (cam_stat.exp_hit)
                begin
                    // fetch the slot payload, free it, advance expected
                    ram_re          = 1'b1;
                    cam_cmd.clr_en  = 1'b1;
                    cam_cmd.clr_idx = cam_stat.exp_idx;
                    deliv_num_next  = exp_reg;
                    exp_next        = exp_reg + SEQ_W'(1);
                    state_next      = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_READ:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    out_kind_next = KIND_DELIVER;
                    out_num_next  = deliv_num_reg;
                    out_tag_next  = ram_rdata[SLOT_DATA_W-1:LEN_W];
                    out_len_next  = ram_rdata[LEN_W-1:0];
                    out_last_next = !cam_stat.exp_hit;
                    state_next    = S_SCAN;
                end
            end
        endcase

        if (load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            win_cfg_reg  <= WIN_RESET;
            exp_reg      <= '0;
            ack_pend_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            exp_reg      <= exp_next;
            ack_pend_reg <= ack_pend_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                win_cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        seq_reg       <= seq_next;
        tag_reg       <= tag_next;
        len_reg       <= len_next;
        deliv_num_reg <= deliv_num_next;
        out_kind_reg  <= out_kind_next;
        out_num_reg   <= out_num_next;
        out_tag_reg   <= out_tag_next;
        out_len_reg   <= out_len_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(64 - SEQ_W - TAG_W - LEN_W){1'b0}}, out_len_reg, out_tag_reg, out_num_reg};

    `SRR_ASSERT_IMPL(a_idle_no_ack, state_reg == S_IDLE, !ack_pend_reg, "pending ack left in idle")
    `SRR_ASSERT_NEXT(a_exp_step, (state_reg == S_SCAN) && !ack_pend_reg && cam_stat.exp_hit, exp_reg == $past(exp_reg) + 32'd1, "expected number did not advance by one")
    `SRR_ASSERT_IMPL(a_deliver_len, load && (out_kind_next == KIND_DELIVER), out_len_next != '0, "delivery from an empty slot")
endmodule

// ===== rtl/selective_repeat_receiver_core.sv =====
// Top level of the selective-repeat receiver window.
//
// Slave channel s_*: one item per packet, s_tuser = action (0 data, 1 FIN).
// Master channel m_*: acks, FIN acks and in-order deliveries, m_tuser = kind,
// m_tlast marks the last result an item causes; data items that are dropped
// give no result at all.
// cfg_wr_en / cfg_wr_data write the receive window size; write only when idle.
// Timing: s_tready is high only while the sequencer is idle, so a new item is
// taken only after the last one is through. Every item passes the idle and
// check states; a FIN item, a stale ack or an empty or oversized item ends
// there. Any other data item adds a scan step, an ack step if it gets one, and
// a slot match and a tag RAM read per delivered packet, with up to 8
// deliveries. The first result is registered from the check state for a FIN
// ack or a stale ack, from the scan state for a new or duplicate ack, and from
// the read state when a delivery comes first. A step that registers a result
// holds while the output register is full. The rate is set by the sequencer
// looping over the slot matcher and the registered tag RAM read.
// Reset: window size 8, expected number 0, every slot free; no clearing pass,
// the tag RAM is read only from occupied slots.
// Stall: while m_tready is low a finished result waits in the output register
// and the sequencer holds with the next result until it is taken.
module selective_repeat_receiver_core
    import srr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [63:0]         s_tdata,   // seq[31:0], payload_tag[47:32], byte_len[58:48]
    input  logic                s_tuser,   // action[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,   // number[31:0], out_tag[47:32], out_len[58:48]
    output logic [KIND_W-1:0]   m_tuser,   // kind[1:0]
    output logic                m_tlast,
    input  logic                cfg_wr_en,
    input  logic [WIN_W-1:0]    cfg_wr_data
);
    cam_cmd_t                 cam_cmd;
    cam_stat_t                cam_stat;
    logic [SEQ_W-1:0]         seq_key;
    logic [SEQ_W-1:0]         exp_key;
    logic [WINC_W-1:0]        win;
    logic                     ram_we;
    logic [SLOT_W-1:0]        ram_waddr;
    logic [SLOT_DATA_W-1:0]   ram_wdata;
    logic                     ram_re;
    logic [SLOT_W-1:0]        ram_raddr;
    logic [SLOT_DATA_W-1:0]   ram_rdata;

    srr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cam_cmd     (cam_cmd),
        .seq_key     (seq_key),
        .exp_key     (exp_key),
        .win         (win),
        .cam_stat    (cam_stat),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    srr_cam u_cam (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cam_cmd),
        .seq_key (seq_key),
        .exp_key (exp_key),
        .win     (win),
        .stat    (cam_stat)
    );

    srr_ram #(
        .DATA_W (SLOT_DATA_W),
        .DEPTH  (WINDOW)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
endmodule

// ===== bench/srr_delivery_checker.sv =====
// Scoreboard for the selective-repeat receiver: predicts acks and deliveries, checks results.
`timescale 1ns / 1ps
module srr_delivery_checker
    import srr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [63:0]       s_tdata,        // seq[31:0], payload_tag[47:32], byte_len[58:48]
    input  logic              s_tuser,        // action[0]
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [63:0]       m_tdata,        // number[31:0], out_tag[47:32], out_len[58:48]
    input  logic [KIND_W-1:0] m_tuser,        // kind[1:0]
    input  logic              m_tlast,
    input  logic              cfg_wr_en,
    input  logic [WIN_W-1:0]  cfg_wr_data,
    output int                mismatch_count,
    output int                responses_due,
    output logic [SEQ_W-1:0]  next_in_order
);

    typedef struct {
        kind_t            kind;
        logic [SEQ_W-1:0] number;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic             last;
    } response_t;

    response_t        expected_responses[$];
    logic [WIN_W-1:0] window_setting;
    logic [SEQ_W-1:0] held_seq  [WINDOW];
    logic             held_free [WINDOW];
    logic [TAG_W-1:0] held_tag  [WINDOW];
    logic [LEN_W-1:0] held_len  [WINDOW];

    function automatic response_t make_response(input kind_t kind,
                                                input logic [SEQ_W-1:0] number,
                                                input logic [TAG_W-1:0] tag,
                                                input logic [LEN_W-1:0] len);
        response_t r;
        r.kind   = kind;
        r.number = number;
        r.tag    = tag;
        r.len    = len;
        r.last   = 1'b0;
        return r;
    endfunction

    function automatic int find_held(input logic [SEQ_W-1:0] s);
        for (int i = 0; i < WINDOW; i++)
            if (!held_free[i] && held_seq[i] == s)
                return i;
        return -1;
    endfunction

    task automatic predict_packet_response(input logic             action,
                                           input logic [SEQ_W-1:0] seq,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [LEN_W-1:0] len);
        response_t        batch[$];
        int               win;
        int               pos;
        logic [SEQ_W-1:0] offset;
        win = (window_setting == 0) ? 1 :
              (window_setting > WINDOW) ? WINDOW : int'(window_setting);
        if (action == ACT_FIN)
            batch.push_back(make_response(KIND_FINACK, next_in_order, '0, '0));
        else if (len != 0 && len <= MAX_PAYLOAD_BYTES) begin
            if (seq < next_in_order)
                batch.push_back(make_response(KIND_ACK, seq, '0, '0));
            else begin
                offset = seq - next_in_order;
                if (find_held(seq) >= 0)
                    batch.push_back(make_response(KIND_ACK, seq, '0, '0));
                else if (offset < win) begin
                    // only the first win slots take new packets; none free means drop
                    for (int j = 0; j < win; j++) begin
                        if (held_free[j]) begin
                            held_free[j] = 1'b0;
                            held_seq[j]  = seq;
                            held_tag[j]  = tag;
                            held_len[j]  = len;
                            batch.push_back(make_response(KIND_ACK, seq, '0, '0));
                            break;
                        end
                    end
                end
                pos = find_held(next_in_order);
                while (pos >= 0 && batch.size() < WINDOW + 1) begin
                    batch.push_back(make_response(KIND_DELIVER, next_in_order,
                                                  held_tag[pos], held_len[pos]));
                    held_free[pos] = 1'b1;
                    next_in_order  = next_in_order + 1'b1;
                    pos = find_held(next_in_order);
                end
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_responses.push_back(batch[i]);
    endtask

    task automatic flag_response(input string why, input response_t want);
        if (mismatch_count < 10)
            $display("%0t %s: expected kind=%0d number=%h tag=%h len=%0d last=%b,",
                     $time, why, want.kind, want.number, want.tag, want.len, want.last,
                     " got kind=%0d number=%h tag=%h len=%0d last=%b",
                     m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[58:48], m_tlast);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        response_t want;
        if (!rst_n)
        begin
            window_setting = WIN_RESET;
            next_in_order  = '0;
            for (int i = 0; i < WINDOW; i++)
            begin
                held_seq[i]  = '1;
                held_free[i] = 1'b1;
                held_tag[i]  = '0;
                held_len[i]  = '0;
            end
            expected_responses.delete();
            mismatch_count = 0;
            responses_due  = 0;
        end
        else
        begin
            if (cfg_wr_en)
                window_setting = cfg_wr_data;
            if (s_tvalid && s_tready)
                predict_packet_response(s_tuser, s_tdata[31:0], s_tdata[47:32],
                                        s_tdata[58:48]);
            if (m_tvalid && m_tready)
            begin
                if (expected_responses.size() == 0)
                begin
                    want = make_response(KIND_ACK, '0, '0, '0);
                    flag_response("unexpected result", want);
                end
                else
                begin
                    want = expected_responses.pop_front();
                    if (m_tuser != want.kind || m_tdata[31:0] != want.number ||
                        m_tdata[47:32] != want.tag || m_tdata[58:48] != want.len ||
                        m_tlast != want.last)
                        flag_response("wrong result", want);
                end
            end
            responses_due = expected_responses.size();
        end
    end

endmodule

// ===== bench/tb_selective_repeat_receiver_core.sv =====
// Testbench top: drives packets and window settings into the receiver and gives the verdict.
`timescale 1ns / 1ps
module tb_selective_repeat_receiver_core;
    import srr_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 23;
    localparam logic [WIN_W-1:0] PHASE_WINDOW [PHASES] = '{3, 1, 0, 8, 15, 5, 2, 4};

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [63:0]       s_tdata     = '0;    // seq[31:0], payload_tag[47:32], byte_len[58:48]
    logic              s_tuser     = 1'b0;  // action[0]
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [63:0]       m_tdata;             // number[31:0], out_tag[47:32], out_len[58:48]
    logic [KIND_W-1:0] m_tuser;             // kind[1:0]
    logic              m_tlast;
    logic              cfg_wr_en   = 1'b0;
    logic [WIN_W-1:0]  cfg_wr_data = '0;

    int                mismatch_count;
    int                responses_due;
    logic [SEQ_W-1:0]  next_in_order;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                cycle_count    = 0;

    selective_repeat_receiver_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    srr_delivery_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .responses_due  (responses_due),
        .next_in_order  (next_in_order)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Entered and left at a falling edge; valid stays high into the next item.
    task automatic send_packet(input logic             action,
                               input logic [SEQ_W-1:0] seq,
                               input logic [TAG_W-1:0] tag,
                               input logic [LEN_W-1:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {5'b0, len, tag, seq};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result is in and the block has settled.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (responses_due != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly in-window packets around the expected number, plus FIN, stale, wild and malformed ones.
    task automatic send_random_packet(input int win, output bit counted);
        int               pick;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] len;
        pick    = $urandom_range(99);
        seq     = next_in_order + $urandom_range(0, win + 1);
        len     = ($urandom_range(15) == 0) ? LEN_W'(MAX_PAYLOAD_BYTES)
                                             : LEN_W'($urandom_range(1, MAX_PAYLOAD_BYTES));
        counted = 1'b1;
        if (pick < 10)
            send_packet(ACT_FIN, $urandom, TAG_W'($urandom), LEN_W'($urandom));
        else
        begin
            if (pick < 18)
            begin
                counted = 1'b0;
                len = $urandom_range(1) ? '0
                                        : LEN_W'($urandom_range(MAX_PAYLOAD_BYTES + 1, 2047));
            end
            else if (pick < 26)
                seq = $urandom;
            else if (pick < 36)
                seq = next_in_order - $urandom_range(1, 12);
            send_packet(ACT_DATA, seq, TAG_W'($urandom), len);
        end
    endtask

    initial
    begin
        int win;
        int sent;
        bit counted;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: FIN, malformed lengths, reorder, duplicate, stale, beyond window
        send_packet(ACT_FIN, $urandom, TAG_W'($urandom), LEN_W'($urandom));
        send_packet(ACT_DATA, 0, 16'h1234, 0);
        send_packet(ACT_DATA, 0, 16'h1234, LEN_W'(MAX_PAYLOAD_BYTES + 1));
        send_packet(ACT_DATA, 0, 16'h1234, 11'h7FF);
        send_packet(ACT_DATA, 2, 16'hFFFF, LEN_W'(MAX_PAYLOAD_BYTES));
        send_packet(ACT_DATA, 2, 16'h0BAD, 9);
        send_packet(ACT_DATA, 1, 16'h0000, 1);
        send_packet(ACT_DATA, 0, 16'hA5A5, 5);
        send_packet(ACT_DATA, 1, 16'h5A5A, 7);
        send_packet(ACT_DATA, 3 + WINDOW, 16'h0F0F, 33);
        send_packet(ACT_DATA, '1, 16'hF0F0, 64);
        for (int s = 4; s <= 9; s++)
            send_packet(ACT_DATA, s, TAG_W'($urandom),
                        LEN_W'($urandom_range(1, MAX_PAYLOAD_BYTES)));

        // shrunk window: no free slot for the expected number, duplicate in an outer slot
        hold_until_drained();
        write_window(2);
        send_packet(ACT_DATA, 3, 16'h3333, 3);
        send_packet(ACT_DATA, 8, 16'h8888, 8);

        // full window: the last missing packet brings one ack and a full run of deliveries
        hold_until_drained();
        write_window(8);
        send_packet(ACT_DATA, 10, TAG_W'($urandom),
                    LEN_W'($urandom_range(1, MAX_PAYLOAD_BYTES)));
        send_packet(ACT_DATA, 3, TAG_W'($urandom),
                    LEN_W'($urandom_range(1, MAX_PAYLOAD_BYTES)));
        send_packet(ACT_FIN, $urandom, TAG_W'($urandom), LEN_W'($urandom));

        for (int p = 0; p < PHASES; p++)
        begin
            hold_until_drained();
            write_window(PHASE_WINDOW[p]);
            win = (PHASE_WINDOW[p] == 0) ? 1 :
                  (PHASE_WINDOW[p] > WINDOW) ? WINDOW : int'(PHASE_WINDOW[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                send_random_packet(win, counted);
                if (counted)
                    sent++;
            end
        end

        hold_until_drained();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/srr_pkg.sv
rtl/srr_ram.sv
rtl/srr_cam.sv
rtl/srr_ctrl.sv
rtl/selective_repeat_receiver_core.sv
bench/srr_delivery_checker.sv
bench/tb_selective_repeat_receiver_core.sv
